// ===== sv/gsr_pkg.sv =====
// Package for the ground to slant range resampler.
// Holds the item kinds, the queue and result record types, the back end states and the register indexes.
// No dependencies.
`default_nettype none

package gsr_pkg;

  // Configuration register indexes
  localparam logic REG_IN_SAMPLES  = 1'b0;
  localparam logic REG_OUT_SAMPLES = 1'b1;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Reset value of the input line length
  localparam logic [13:0] IN_SAMPLES_RST = 14'd8192;

  // Item kinds after classification
  typedef enum logic [1:0] {
    K_LOAD,
    K_SAMPLE,
    K_SKIP
  } gsr_kind_e;

  // Classified item as held in the front queue
  typedef struct packed {
    gsr_kind_e          kind;
    logic [12:0]        index;
    logic [12:0]        position;
    logic [11:0]        fraction;
    logic signed [15:0] sample;
  } gsr_cmd_t;

  // Result write from the back end into the result buffer
  typedef struct packed {
    logic               wr;
    logic               fin;
    logic               over;
    logic               done;
    logic signed [15:0] pixel;
    logic [12:0]        index;
  } gsr_res_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_START,
    B_SCAN,
    B_END
  } gsr_back_state_e;

endpackage : gsr_pkg

`default_nettype wire

// ===== sv/gsr_front.sv =====
// Front end: accepts items, classifies them and holds them in a short queue.
// Depends on gsr_pkg.
`default_nettype none

module gsr_front #(
  parameter int LINE_MAX = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               cmd,
  input  wire logic [12:0]        entry_index,
  input  wire logic [12:0]        entry_position,
  input  wire logic [11:0]        entry_fraction,
  input  wire logic signed [15:0] sample,
  output logic                    q_valid,
  output gsr_pkg::gsr_cmd_t       q_item,
  input  wire logic               q_pop
);
  import gsr_pkg::*;

  gsr_cmd_t    slots [Q_DEPTH];
  gsr_cmd_t    item_in;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;
  logic [31:0] idx32;

  // Classify the incoming item
  always_comb begin
    idx32            = 32'(entry_index);
    item_in.index    = entry_index;
    item_in.position = entry_position;
    item_in.fraction = entry_fraction;
    item_in.sample   = sample;
    if (cmd) begin
      item_in.kind = K_SAMPLE;
    end else if (idx32 < LINE_MAX) begin
      item_in.kind = K_LOAD;
    end else begin
      item_in.kind = K_SKIP;
    end
  end

  assign full    = (count == 2'(Q_DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule : gsr_front

`default_nettype wire

// ===== sv/gsr_back.sv =====
// Back end: coefficient table, line scan sequencer and interpolation pipeline.
// Depends on gsr_pkg; feeds gsr_resq.
`default_nettype none

module gsr_back #(
  parameter int LINE_MAX  = 8192,
  parameter int FRAC_BITS = 12,
  parameter int MAX_OUT   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [13:0]       in_samples,
  input  wire logic [13:0]       out_samples,
  input  wire logic              q_valid,
  input  wire gsr_pkg::gsr_cmd_t q_item,
  output logic                   q_pop,
  input  wire logic              busy,
  output gsr_pkg::gsr_res_t      res
);
  import gsr_pkg::*;

  localparam int AW = $clog2(LINE_MAX);
  localparam int NW = ($clog2(LINE_MAX + 1) > 14) ? $clog2(LINE_MAX + 1) : 14;
  localparam int CW = $clog2(MAX_OUT + 1);
  localparam int EW = 13 + FRAC_BITS;
  localparam int PW = FRAC_BITS + 18;

  gsr_back_state_e state, state_next;

  // Table memory
  logic [EW-1:0] tab [LINE_MAX];
  logic [EW-1:0] rd_entry;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [31:0]   idx32;
  logic [31:0]   frac32;

  // Scan state
  logic [NW-1:0]      ptr;
  logic [13:0]        s_cnt;
  logic signed [15:0] prev_smp;
  logic signed [15:0] cur_smp;
  logic [CW-1:0]      n_cnt;
  logic               over;
  logic               done;

  // Scan evaluation
  logic [13:0]        np;
  logic [13:0]        np_m1;
  logic [NW-1:0]      nout;
  logic [NW-1:0]      ptr_inc;
  logic [12:0]        ent_pos;
  logic [13:0]        pos_ext;
  logic [13:0]        pos_up;
  logic [13:0]        up_i;
  logic [13:0]        lo_i;
  logic [14:0]        s_inc;
  logic               line_close;
  logic               brk;
  logic               at_end;
  logic               in_scan;
  logic               due;
  logic               emit;
  logic               fin;
  logic               take_smp;
  logic signed [15:0] lo_v;
  logic signed [15:0] hi_v;

  // Pipeline stages
  logic                 s1_valid, s1_fin, s1_over, s1_done;
  logic [15:0]          s1_base;
  logic signed [16:0]   s1_diff;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [12:0]          s1_index;
  logic                 s2_valid, s2_fin, s2_over, s2_done;
  logic [15:0]          s2_base;
  logic signed [PW-1:0] s2_prod;
  logic [12:0]          s2_index;
  logic [PW-1:0]        half_q;
  logic signed [PW-1:0] acc;

  // Line geometry and the due test for the entry under the pointer
  always_comb begin
    np         = (in_samples == 14'd0) ? 14'd1 : in_samples;
    np_m1      = np - 14'd1;
    nout       = (NW'(out_samples) < NW'(LINE_MAX)) ? NW'(out_samples) : NW'(LINE_MAX);
    ptr_inc    = ptr + NW'(1);
    ent_pos    = rd_entry[EW-1:FRAC_BITS];
    pos_ext    = {1'b0, ent_pos};
    pos_up     = pos_ext + 14'd1;
    up_i       = (pos_up > np_m1) ? np_m1 : pos_up;
    lo_i       = (pos_ext > np_m1) ? np_m1 : pos_ext;
    s_inc      = {1'b0, s_cnt} + 15'd1;
    line_close = (s_inc >= {1'b0, np});
    brk        = (up_i > s_cnt) && !line_close;
    at_end     = (ptr >= nout);
    in_scan    = (state == B_SCAN);
    due        = in_scan && !at_end && !brk;
    emit       = due && (n_cnt < CW'(MAX_OUT));
    fin        = in_scan && !due;
    lo_v       = (lo_i >= s_cnt) ? cur_smp : prev_smp;
    hi_v       = (up_i >= s_cnt) ? cur_smp : prev_smp;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (take_smp) state_next = B_START;
      B_START: state_next = B_SCAN;
      B_SCAN:  if (fin) state_next = B_END;
      B_END:   if (s2_fin) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = (state == B_IDLE) && q_valid && ((q_item.kind != K_SAMPLE) || !busy);
    wr_en    = q_pop && (q_item.kind == K_LOAD);
    take_smp = q_pop && (q_item.kind == K_SAMPLE);
    rd_addr  = due ? ptr_inc[AW-1:0] : ptr[AW-1:0];
    idx32    = 32'(q_item.index);
    wr_addr  = idx32[AW-1:0];
    frac32   = 32'(q_item.fraction);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Coefficient table: position and fraction per output pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab[wr_addr] <= {q_item.position, frac32[FRAC_BITS-1:0]};
    end
    rd_entry <= tab[rd_addr];
  end

  // Line counters and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      s_cnt    <= 14'd0;
      prev_smp <= 16'sd0;
      n_cnt    <= '0;
      over     <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (take_smp) begin
        n_cnt <= '0;
        over  <= 1'b0;
        done  <= 1'b0;
      end
      if (due) begin
        ptr <= ptr_inc;
        if (emit) begin
          n_cnt <= n_cnt + CW'(1);
        end else begin
          over <= 1'b1;
        end
        if (ptr_inc == nout) begin
          done <= 1'b1;
        end
      end
      if (fin) begin
        prev_smp <= cur_smp;
        if (line_close) begin
          s_cnt <= 14'd0;
          ptr   <= '0;
        end else begin
          s_cnt <= s_inc[13:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_smp) begin
      cur_smp <= q_item.sample;
    end
  end

  // Stage 1: operand select, base and difference
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fin   <= 1'b0;
    end else begin
      s1_valid <= emit;
      s1_fin   <= fin;
    end
    s1_over  <= over;
    s1_done  <= done;
    s1_base  <= lo_v ^ 16'h8000;
    s1_diff  <= {hi_v[15], hi_v} - {lo_v[15], lo_v};
    s1_frac  <= rd_entry[FRAC_BITS-1:0];
    s1_index <= ptr[12:0];
  end

  // Stage 2: difference times fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_fin   <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s2_fin   <= s1_fin;
    end
    s2_over  <= s1_over;
    s2_done  <= s1_done;
    s2_base  <= s1_base;
    s2_prod  <= s1_diff * $signed({1'b0, s1_frac});
    s2_index <= s1_index;
  end

  // Add the base, round half up, drop the bias
  always_comb begin
    half_q = {{(PW - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    acc    = $signed({2'b00, s2_base, {FRAC_BITS{1'b0}}}) + s2_prod + $signed(half_q);
    res.wr    = s2_valid;
    res.fin   = s2_fin;
    res.over  = s2_over;
    res.done  = s2_done;
    res.pixel = {~acc[FRAC_BITS+15], acc[FRAC_BITS+14:FRAC_BITS]};
    res.index = s2_index;
  end

endmodule : gsr_back

`default_nettype wire

// ===== sv/gsr_resq.sv =====
// Result buffer: collects the pixels of one sample, then hands them out in order
// with the per-sample flags. Depends on gsr_pkg; fed by gsr_back.
`default_nettype none

module gsr_resq #(
  parameter int MAX_OUT = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gsr_pkg::gsr_res_t  res,
  output logic                    busy,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      pixel,
  output logic [12:0]             pixel_index,
  output logic                    last,
  output logic                    line_done,
  output logic                    overflow
);
  import gsr_pkg::*;

  localparam int BW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int CW = $clog2(MAX_OUT + 1);

  logic [28:0]   buf_mem [MAX_OUT];
  logic [28:0]   rdata;
  logic [CW-1:0] wr_cnt;
  logic [CW-1:0] tot;
  logic [CW-1:0] out_idx;
  logic [CW-1:0] out_idx_inc;
  logic [BW-1:0] rd_addr;
  logic          o_valid;
  logic          o_over;
  logic          o_done;
  logic          adv;
  logic          more;
  logic          start;
  logic          load_rd;

  always_comb begin
    out_idx_inc = out_idx + CW'(1);
    adv         = pop && o_valid;
    more        = (out_idx_inc < tot);
    start       = res.fin && (wr_cnt != '0);
    load_rd     = start || (adv && more);
    rd_addr     = start ? '0 : out_idx_inc[BW-1:0];
  end

  // Buffer write and registered read
  always_ff @(posedge clk) begin
    if (res.wr) begin
      buf_mem[wr_cnt[BW-1:0]] <= {res.pixel, res.index};
    end
    if (load_rd) begin
      rdata <= buf_mem[rd_addr];
    end
  end

  // Fill count and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt  <= '0;
      tot     <= '0;
      out_idx <= '0;
      o_valid <= 1'b0;
      o_over  <= 1'b0;
      o_done  <= 1'b0;
    end else begin
      if (res.fin) begin
        wr_cnt <= '0;
      end else if (res.wr) begin
        wr_cnt <= wr_cnt + CW'(1);
      end
      if (start) begin
        o_valid <= 1'b1;
        out_idx <= '0;
        tot     <= wr_cnt;
        o_over  <= res.over;
        o_done  <= res.done;
      end else if (adv) begin
        if (more) begin
          out_idx <= out_idx_inc;
        end else begin
          o_valid <= 1'b0;
        end
      end
    end
  end

  assign busy        = o_valid;
  assign empty       = !o_valid;
  assign pixel       = rdata[28:13];
  assign pixel_index = rdata[12:0];
  assign last        = (out_idx_inc == tot);
  assign line_done   = last && o_done;
  assign overflow    = o_over;

endmodule : gsr_resq

`default_nettype wire

// ===== sv/ground_to_slant_range_resampler.sv =====
// Ground to slant range resampler, top level: configuration registers, front, back, buffer.
// A table load is popped from the queue only while the back end is idle. A sample item holds
// the back end while it scans the pixels it makes due (dropped ones included), one table read
// per pixel; its pixels are handed out once the whole sample is scanned, and the next sample
// is taken only once all its pixels (at most MAX_OUT) have been popped.
// Reset clears all control state; in_samples resets to 8192, out_samples to 0.
`default_nettype none

module ground_to_slant_range_resampler #(
  parameter int LINE_MAX  = 8192,
  parameter int FRAC_BITS = 12,
  parameter int MAX_OUT   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               cmd,
  input  wire logic [12:0]        entry_index,
  input  wire logic [12:0]        entry_position,
  input  wire logic [11:0]        entry_fraction,
  input  wire logic signed [15:0] sample,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      pixel,
  output logic [12:0]             pixel_index,
  output logic                    last,
  output logic                    line_done,
  output logic                    overflow,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [13:0]        cfg_data
);
  import gsr_pkg::*;

  logic [13:0] in_samples;
  logic [13:0] out_samples;
  logic        q_valid;
  gsr_cmd_t    q_item;
  logic        q_pop;
  logic        busy;
  gsr_res_t    res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_samples  <= IN_SAMPLES_RST;
      out_samples <= 14'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_SAMPLES:  in_samples  <= cfg_data;
        REG_OUT_SAMPLES: out_samples <= cfg_data;
        default:         in_samples  <= in_samples;
      endcase
    end
  end

  gsr_front #(
    .LINE_MAX(LINE_MAX)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .entry_index   (entry_index),
    .entry_position(entry_position),
    .entry_fraction(entry_fraction),
    .sample        (sample),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  gsr_back #(
    .LINE_MAX (LINE_MAX),
    .FRAC_BITS(FRAC_BITS),
    .MAX_OUT  (MAX_OUT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_samples (in_samples),
    .out_samples(out_samples),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .busy       (busy),
    .res        (res)
  );

  gsr_resq #(
    .MAX_OUT(MAX_OUT)
  ) u_resq (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .busy       (busy),
    .empty      (empty),
    .pop        (pop),
    .pixel      (pixel),
    .pixel_index(pixel_index),
    .last       (last),
    .line_done  (line_done),
    .overflow   (overflow)
  );

endmodule : ground_to_slant_range_resampler

`default_nettype wire

// ===== bench/ground_to_slant_range_resampler_tb.sv =====
// Self-checking bench for ground_to_slant_range_resampler: table loads and sample items in,
// interpolated pixels out, each compared with a local prediction of the line resampler.
// Depends on gsr_pkg (register indexes) and the resampler RTL.
module ground_to_slant_range_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsr_pkg::*;

  localparam int LINE_MAX     = 8192;
  localparam int FRAC_W       = 12;
  localparam int MAX_OUT      = 16;
  localparam longint ONE_Q    = longint'(1) << FRAC_W;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TOTAL_ITEMS  = 130;
  localparam int PRINT_LIMIT  = 40;

  // Item kinds on the cmd port
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Receiver stall patterns
  localparam int RX_FREE  = 0;
  localparam int RX_COIN  = 1;
  localparam int RX_STALL = 2;

  // One expected pixel
  typedef struct packed {
    logic signed [15:0] value;
    logic [12:0]        index;
    logic               fin;
    logic               done;
    logic               over;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic cmd;
  logic [12:0] entry_index;
  logic [12:0] entry_position;
  logic [11:0] entry_fraction;
  logic signed [15:0] sample;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] pixel;
  logic [12:0] pixel_index;
  logic last;
  logic line_done;
  logic overflow;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [13:0] cfg_data;

  ground_to_slant_range_resampler dut (
    .clk, .rst, .push, .full, .cmd, .entry_index, .entry_position, .entry_fraction,
    .sample, .empty, .pop, .pixel, .pixel_index, .last, .line_done, .overflow,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // Predicted resampler state
  logic [12:0]        tbl_pos  [0:LINE_MAX-1];
  logic [11:0]        tbl_frac [0:LINE_MAX-1];
  bit                 loaded   [0:LINE_MAX-1];
  logic signed [15:0] prev_smp;
  int unsigned        smp_cnt;
  int unsigned        out_ptr;
  logic [13:0]        in_len;
  logic [13:0]        out_len;
  pixel_t             pixel_q[$];

  int mismatches  = 0;
  int burst_left  = 0;
  int work_budget = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int rx_mode     = RX_FREE;
  int rx_hold     = 0;

  function automatic int unsigned eff_in();
    return (in_len == 0) ? 1 : in_len;
  endfunction

  function automatic int unsigned eff_out();
    return (out_len > LINE_MAX) ? LINE_MAX : out_len;
  endfunction

  // Lower and upper source index of pixel p, both clipped to the last input sample
  function automatic void source_span(input int unsigned p, output int unsigned lo,
                                      output int unsigned up);
    int unsigned pos, top;
    top = eff_in() - 1;
    pos = tbl_pos[p];
    up  = (pos + 1 > top) ? top : pos + 1;
    lo  = (pos > top) ? top : pos;
  endfunction

  // A pixel is due once its upper sample is the current one, or when the line closes
  function automatic bit pixel_due(input int unsigned p);
    int unsigned lo, up;
    source_span(p, lo, up);
    return !(up > smp_cnt && smp_cnt + 1 < eff_in());
  endfunction

  // Rounded two-tap blend, Q0.12 weight on the upper sample
  function automatic logic signed [15:0] blend(input logic signed [15:0] lo_v,
                                               input logic signed [15:0] hi_v,
                                               input logic [11:0] fr);
    longint a, b, acc;
    a   = longint'(lo_v) + 32768;
    b   = longint'(hi_v) + 32768;
    acc = a * (ONE_Q - longint'(fr)) + b * longint'(fr) + (ONE_Q >> 1);
    return 16'((acc >>> FRAC_W) - 32768);
  endfunction

  function automatic void clear_resampler();
    for (int i = 0; i < LINE_MAX; i++) loaded[i] = 1'b0;
    prev_smp = '0;
    smp_cnt  = 0;
    out_ptr  = 0;
    in_len   = 14'd8192;
    out_len  = 14'd0;
  endfunction

  // One sample item: queue every due pixel, return how many fell due (dropped ones too)
  function automatic int unsigned resample(input logic signed [15:0] smp);
    pixel_t batch [MAX_OUT];
    int n;
    int unsigned due, np, nout, s, lo, up;
    bit over, done, done_out;
    logic signed [15:0] lo_v, hi_v;
    n = 0;
    due = 0;
    over = 1'b0;
    done = 1'b0;
    done_out = 1'b0;
    np = eff_in();
    nout = eff_out();
    s = smp_cnt;
    while (out_ptr < nout) begin
      if (!pixel_due(out_ptr)) break;
      source_span(out_ptr, lo, up);
      due++;
      // late entries read the previous sample
      lo_v = (lo >= s) ? smp : prev_smp;
      hi_v = (up >= s) ? smp : prev_smp;
      if (n < MAX_OUT) begin
        batch[n] = '{blend(lo_v, hi_v, tbl_frac[out_ptr]), 13'(out_ptr), 1'b0,
                     (out_ptr + 1 == nout), 1'b0};
        if (out_ptr + 1 == nout) done_out = 1'b1;
        n++;
      end else begin
        over = 1'b1;
      end
      out_ptr++;
      if (out_ptr == nout) done = 1'b1;
    end
    if (n > 0) begin
      batch[n-1].fin = 1'b1;
      // final pixel dropped: the last one sent carries line_done
      if (done && !done_out) batch[n-1].done = 1'b1;
      for (int i = 0; i < n; i++) begin
        batch[i].over = over;
        pixel_q.push_back(batch[i]);
      end
    end
    prev_smp = smp;
    if (s + 1 >= np) begin
      smp_cnt = 0;
      out_ptr = 0;
    end else begin
      smp_cnt = s + 1;
    end
    return due;
  endfunction

  // Source position roughly following the line geometry, with jitter and the odd wild one
  function automatic logic [12:0] pick_position(input int unsigned p);
    int base;
    if ($urandom_range(0, 15) == 0) return 13'($urandom);
    base = (eff_out() == 0) ? 0 : int'((longint'(p) * eff_in()) / eff_out());
    base += int'($urandom_range(0, 2)) - 1;
    if (base < 0) base = 0;
    if (base > LINE_MAX - 1) base = LINE_MAX - 1;
    return 13'(base);
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want,
                                 input int at);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch at pixel %0d: got %0d, expected %0d",
               $realtime, field, at, got, want);
    mismatches++;
  endtask

  // Send one item, with random idle gaps between bursts; push is left high on return
  task automatic push_item(input logic c, input logic [12:0] idx, input logic [12:0] pos,
                           input logic [11:0] fr, input logic signed [15:0] smp);
    int gap;
    int unsigned due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push           <= 1'b1;
    cmd            <= c;
    entry_index    <= idx;
    entry_position <= pos;
    entry_fraction <= fr;
    sample         <= smp;
    do @(posedge clk); while (full);
    burst_left--;
    items_sent++;
    if (c == CMD_LOAD) begin
      tbl_pos[idx]  = pos;
      tbl_frac[idx] = fr;
      loaded[idx]   = 1'b1;
      work_budget  += 2;
    end else begin
      due = resample(smp);
      // remaining work after the last pixel is out: this item's scan plus later ones
      if (due > 0) work_budget = due + 8;
      else work_budget += 8;
    end
  endtask

  task automatic load_entry(input logic [12:0] idx, input logic [12:0] pos,
                            input logic [11:0] fr);
    push_item(CMD_LOAD, idx, pos, fr, 16'($urandom));
  endtask

  // Load any unwritten entry the sample would read, then send the sample
  task automatic send_sample(input logic signed [15:0] smp);
    int unsigned p;
    p = out_ptr;
    while (p < eff_out()) begin
      if (!loaded[p]) load_entry(13'(p), pick_position(p), 12'($urandom));
      if (!pixel_due(p)) break;
      p++;
    end
    push_item(CMD_SAMPLE, 13'($urandom), 13'($urandom), 12'($urandom), smp);
  endtask

  // Stop sending, wait for every pixel, then let the block finish any trailing work
  task automatic settle_block();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (work_budget + 16) @(posedge clk);
    work_budget = 0;
  endtask

  // Write both line lengths, valid held across the pair
  task automatic set_lines(input logic [13:0] in_n, input logic [13:0] out_n);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= REG_IN_SAMPLES;
    cfg_data  <= in_n;
    do @(posedge clk); while (!cfg_ready);
    in_len = in_n;
    cfg_index <= REG_OUT_SAMPLES;
    cfg_data  <= out_n;
    do @(posedge clk); while (!cfg_ready);
    out_len = out_n;
    cfg_valid <= 1'b0;
  endtask

  // Reset lengths: loads at the field extremes, samples make no pixels
  task automatic test_idle_defaults();
    load_entry(13'd8191, 13'd8191, 12'd4095);
    load_entry(13'd4096, 13'd4096, 12'd2048);
    load_entry(13'd0, 13'd0, 12'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // Lengths changed with a line open: counters carry on, next sample closes the line
  task automatic test_register_change_mid_line();
    set_lines(14'd16383, 14'd3);
    send_sample(random_sample());
    send_sample(random_sample());
    set_lines(14'd4, 14'd3);
    send_sample(random_sample());
  endtask

  // Clean four-sample line: fraction extremes, clipped positions and late entries
  task automatic test_line_interpolation();
    set_lines(14'd4, 14'd7);
    load_entry(13'd0, 13'd0, 12'd0);
    load_entry(13'd1, 13'd0, 12'd4095);
    load_entry(13'd2, 13'd1, 12'd2048);
    load_entry(13'd3, 13'd3, 12'd100);
    load_entry(13'd4, 13'd8191, 12'd4095);
    load_entry(13'd5, 13'd1, 12'd3000);
    load_entry(13'd6, 13'd2, 12'd1);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'shffff);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'sh3039);
  endtask

  // Input length zero acts as one: every sample closes the line
  task automatic test_zero_input_length();
    set_lines(14'd0, 14'd3);
    repeat (3) send_sample(random_sample());
  endtask

  // More pixels due on one sample than can be sent
  task automatic test_surplus_dropped();
    set_lines(14'd2, 14'd20);
    repeat (2) send_sample(random_sample());
  endtask

  // Both lengths beyond the line maximum; the start of a long line, left open
  task automatic test_full_output_length();
    set_lines(14'd16383, 14'd16383);
    repeat (6) send_sample(random_sample());
  endtask

  // Random line lengths and item mix until the item total is reached, one full drain
  task automatic test_random_lines();
    int phase_len, pick, span_n;
    bit drained;
    logic [13:0] in_n, out_n;
    drained = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 9);
      in_n = (pick == 0) ? 14'd0 : (pick == 1) ? 14'd16383 : (pick == 2) ? 14'd1 :
             14'($urandom_range(2, 40));
      out_n = ($urandom_range(0, 9) == 0) ? 14'd0 : 14'($urandom_range(1, 48));
      set_lines(in_n, out_n);
      phase_len = $urandom_range(15, 35);
      repeat (phase_len) begin
        if (items_sent >= TOTAL_ITEMS) break;
        pick = $urandom_range(0, 99);
        span_n = (eff_out() == 0) ? 1 : eff_out();
        if (pick < 70)
          send_sample(random_sample());
        else if (pick < 85)
          load_entry(13'($urandom_range(0, span_n - 1)), pick_position(0), 12'($urandom));
        else
          load_entry(13'($urandom), 13'($urandom), 12'($urandom));
        if (!drained && items_sent >= (TOTAL_ITEMS * 3) / 4) begin
          settle_block();
          drained = 1'b1;
        end
      end
    end
  endtask

  // Receiver: free running, coin toss or occasional long stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: pop <= 1'b1;
        RX_COIN: pop <= 1'($urandom_range(0, 1));
        default: begin
          pop <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 12);
        end
      endcase
      if ($urandom_range(0, 99) == 0) rx_mode <= $urandom_range(RX_FREE, RX_STALL);
    end
  end

  // Compare each accepted pixel with the oldest expected one
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pop && !empty) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected item", pixel_index, -1, pixel_index);
      end else begin
        want = pixel_q.pop_front();
        if (pixel !== want.value) report_mismatch("pixel", pixel, want.value, want.index);
        if (pixel_index !== want.index)
          report_mismatch("pixel_index", pixel_index, want.index, want.index);
        if (last !== want.fin) report_mismatch("last", last, want.fin, want.index);
        if (line_done !== want.done)
          report_mismatch("line_done", line_done, want.done, want.index);
        if (overflow !== want.over)
          report_mismatch("overflow", overflow, want.over, want.index);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst            <= 1'b1;
    push           <= 1'b0;
    cmd            <= CMD_LOAD;
    entry_index    <= '0;
    entry_position <= '0;
    entry_fraction <= '0;
    sample         <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_IN_SAMPLES;
    cfg_data       <= '0;
    clear_resampler();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_defaults();
    test_register_change_mid_line();
    test_line_interpolation();
    test_zero_input_length();
    test_surplus_dropped();
    test_full_output_length();
    test_random_lines();
    settle_block();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
